// ===== rtl/psq_pkg.sv =====
// shared types and constants for the paced switch command queue
// item and result layouts, reset values and op codes; no dependencies

package psq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ADDR_W          = 11;
  localparam int INTERVAL_W      = 10;
  localparam int TICKS_W         = 11;
  localparam int COUNT_OUT_W     = 5;
  localparam int ENTRY_W         = ADDR_W + 1;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd50;
  localparam logic [TICKS_W-1:0]    TICKS_MAX      = 11'd2047;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_POST = 1'b1;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] address;
    logic              direction;
  } item_t;

  typedef struct packed {
    logic                   accepted;
    logic                   send_valid;
    logic [ADDR_W-1:0]      send_address;
    logic                   send_direction;
    logic                   coil_on;
    logic [COUNT_OUT_W-1:0] queue_count;
  } result_t;

endpackage

// ===== rtl/paced_switch_command_queue_unit.sv =====
// paced switch command queue: ring fifo of switch requests drained at a paced rate
// uses psq_pkg for item/result types and psq_ram for the entry store
//
// usage:
//   cmd channel: an item is taken at a rising edge with start high and busy low.
//     op tick advances the millisecond counter and may send the head request;
//     op post enqueues address/direction at the tail if there is room.
//   result channel: done is high for exactly one cycle, in the cycle after the item
//     was taken, with the result on the result port. there is no backpressure.
//   cfg_we/cfg_data write send_interval at any edge outside reset; write it only while idle.
// timing:
//   a new item can be taken every cycle while busy is low: all queue state updates
//   at the accept edge, and the only memory access per item is one read of the head
//   entry (tick) or one write of the tail entry (post), so the entry ram port pair
//   sets the one-item-per-cycle rate.
// reset:
//   rst (synchronous) empties the queue, clears the tick counter and the coil-on
//   flag and loads send_interval with 50. busy is set by reset and cleared at the next
//   edge without rst. the entry store is not cleared; the count keeps reads in range.

module paced_switch_command_queue_unit
  import psq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 cmd,
  input  logic                  cfg_we,
  input  logic [INTERVAL_W-1:0] cfg_data,
  output logic                  done,
  output result_t               result
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  logic [IW-1:0]         head, head_next;
  logic [IW-1:0]         tail, tail_next;
  logic [CW-1:0]         count, count_next;
  logic                  head_on_sent, head_on_sent_next;
  logic [TICKS_W-1:0]    ticks, ticks_next;
  logic [INTERVAL_W-1:0] send_interval;

  logic                  accept;
  logic [TICKS_W-1:0]    ticks_inc;
  logic                  do_send;
  logic                  do_store;

  logic                  res_accepted;
  logic                  res_send;
  logic                  res_coil;
  logic [CW-1:0]         res_count;

  logic [ENTRY_W-1:0]    head_entry;

  assign accept = start && !busy;

  always_comb begin
    head_next         = head;
    tail_next         = tail;
    count_next        = count;
    head_on_sent_next = head_on_sent;
    ticks_next        = ticks;
    ticks_inc         = (ticks < TICKS_MAX) ? ticks + 1'b1 : ticks;
    do_send           = 1'b0;
    do_store          = 1'b0;
    if (accept) begin
      if (cmd.op == OP_POST) begin
        if (count < FULL_COUNT) begin
          do_store   = 1'b1;
          tail_next  = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
          count_next = count + 1'b1;
        end
      end else begin
        ticks_next = ticks_inc;
        if (count != '0 && ticks_inc > {1'b0, send_interval}) begin
          do_send    = 1'b1;
          ticks_next = '0;
          if (!head_on_sent) begin
            head_on_sent_next = 1'b1;
          end else begin
            head_on_sent_next = 1'b0;
            head_next         = (head == LAST_SLOT) ? '0 : head + 1'b1;
            count_next        = count - 1'b1;
          end
        end
      end
    end
  end

  // head is read every cycle; the ram registers the read, and a send's result uses that registered data
  psq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (do_store),
    .waddr(tail),
    .wdata({cmd.direction, cmd.address}),
    .raddr(head),
    .rdata(head_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      head_on_sent  <= 1'b0;
      ticks         <= '0;
      send_interval <= INTERVAL_RESET;
      busy          <= 1'b1;
      done          <= 1'b0;
    end else begin
      head         <= head_next;
      tail         <= tail_next;
      count        <= count_next;
      head_on_sent <= head_on_sent_next;
      ticks        <= ticks_next;
      busy         <= 1'b0;
      done         <= accept;
      if (cfg_we) begin
        send_interval <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_accepted <= do_store;
    res_send     <= do_send;
    res_coil     <= do_send && !head_on_sent;
    res_count    <= count_next;
  end

  always_comb begin
    result.accepted       = res_accepted;
    result.send_valid     = res_send;
    result.send_address   = res_send ? head_entry[ADDR_W-1:0] : '0;
    result.send_direction = res_send && head_entry[ADDR_W];
    result.coil_on        = res_coil;
    result.queue_count    = COUNT_OUT_W'(res_count);
  end

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted item produced no result strobe");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result strobe without an accepted item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue count beyond depth");

  a_post_never_sends: assert property (@(posedge clk) disable iff (rst)
    done && result.accepted |-> !result.send_valid)
    else $error("post item emitted a send");

  a_coil_flag_needs_entry: assert property (@(posedge clk) disable iff (rst)
    head_on_sent |-> count != '0)
    else $error("coil-on flag set with empty queue");

endmodule

// ===== rtl/psq_ram.sv =====
// generic single-port-write, single-read ram with registered read data
// no dependencies

module psq_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
